// ===== sv/dba_pkg.sv =====
// Shared types, codes and widths of the disk block allocation bitmap.
// No dependencies; every other file of the block but dba_fifo imports this package.
package dba_pkg;

  localparam int BLOCK_COUNT_DEF = 128;
  localparam int BLOCK_W         = 7;
  localparam int LEN_W           = 8;
  localparam int DISK_W          = 8;
  localparam int REQ_W           = 2;
  localparam int STATUS_W        = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [DISK_W-1:0] DISK_SIZE_RESET = 8'd100;

  // Request types, also used as back-end command codes.
  localparam logic [REQ_W-1:0] REQ_CONTIG = 2'd0;
  localparam logic [REQ_W-1:0] REQ_HEAD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MEMBER = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HEAD_TAKEN   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MEMBER_TAKEN = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   op;
    logic [BLOCK_W-1:0] blk;
    logic [LEN_W-1:0]   end_blk;
    logic               in_range;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  fail_block;
  } res_t;

endpackage

// ===== sv/disk_block_allocation_bitmap.sv =====
// Top level of the disk block allocation bitmap: front end, command queue,
// back end and result queue. Depends on dba_pkg, dba_fifo, dba_front, dba_back.
//
// Keeps one allocation bit per disk block, all free after reset. A request
// beat is taken when push is high and full is low; results come out of a
// queue and are taken when pop is high and empty is low. A contiguous claim
// (start block, run length) always gives one result; list claims open with a
// head beat, add member beats and give one result on the beat marked last,
// committing head and members all or nothing. The front end accepts one beat
// per cycle while the two-entry command queue has room; member beats with no
// open list and unused request types are dropped there and cost nothing
// further. The back end handles a list beat in a single step; a contiguous
// claim stages its run mask, then searches the whole bitmap for the first
// conflict, and no new beat is taken until it has reported. Sustained rate
// is one list beat per cycle until the two-entry result queue fills. disk_size
// is written through the cfg channel, always ready; write it only while the
// block is idle.
module disk_block_allocation_bitmap #(
  parameter int BLOCK_COUNT = dba_pkg::BLOCK_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [dba_pkg::REQ_W-1:0]      req_type,
  input  logic [dba_pkg::BLOCK_W-1:0]    block,
  input  logic [dba_pkg::LEN_W-1:0]      run_length,
  input  logic                           last,
  output logic                           empty,
  input  logic                           pop,
  output logic [dba_pkg::STATUS_W-1:0]   status,
  output logic [dba_pkg::BLOCK_W-1:0]    fail_block,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dba_pkg::DISK_W-1:0]     cfg_data
);
  import dba_pkg::*;

  localparam int SIZE_W = $clog2(BLOCK_COUNT + 1);
  localparam int UW     = (SIZE_W > DISK_W) ? SIZE_W : DISK_W;
  localparam logic [UW-1:0] BC_U = UW'(BLOCK_COUNT);

  logic [DISK_W-1:0] disk_size;
  logic [UW-1:0]     used_wide;
  logic [SIZE_W-1:0] used_size;

  cmd_t front_cmd;
  cmd_t back_cmd;
  res_t back_res;
  res_t out_res;
  logic accept;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic res_push, res_full;

  // config register: always ready, a beat lands at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size <= DISK_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      disk_size <= cfg_data;
    end
  end

  // clamp the disk size to the bitmap depth
  assign used_wide = (UW'(disk_size) > BC_U) ? BC_U : UW'(disk_size);
  assign used_size = SIZE_W'(used_wide);

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  dba_front #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req_type),
    .block      (block),
    .run_length (run_length),
    .last       (last),
    .used_size  (used_size),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  dba_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (cmd_full),
    .din   (front_cmd),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (back_cmd)
  );

  dba_back #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  dba_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (back_res),
    .pop   (pop),
    .empty (empty),
    .dout  (out_res)
  );

  assign status     = out_res.status;
  assign fail_block = out_res.fail_block;

endmodule

// ===== sv/dba_fifo.sv =====
// Small register queue used between front and back end and on the result side.
// Depends on nothing; depth must be a power of two.
module dba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/dba_front.sv =====
// Front end: takes request beats, range-checks them and drops ones with no effect.
// Depends on dba_pkg; feeds the command queue.
module dba_front #(
  parameter int BLOCK_COUNT = dba_pkg::BLOCK_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [dba_pkg::REQ_W-1:0]       req_type,
  input  logic [dba_pkg::BLOCK_W-1:0]     block,
  input  logic [dba_pkg::LEN_W-1:0]       run_length,
  input  logic                            last,
  input  logic [$clog2(BLOCK_COUNT+1)-1:0] used_size,
  output logic                            cmd_push,
  output dba_pkg::cmd_t                   cmd
);
  import dba_pkg::*;

  localparam int SIZE_W = $clog2(BLOCK_COUNT + 1);
  localparam int CMP_W  = (SIZE_W > LEN_W) ? SIZE_W : LEN_W;
  localparam int SUM_W  = CMP_W + 1;

  logic             list_open;
  logic             list_open_next;
  logic [SUM_W-1:0] end_sum;
  logic [LEN_W-1:0] end_blk;
  logic             keep;

  // keep the carry: start plus length can pass the top of the length field
  assign end_sum = SUM_W'(block) + SUM_W'(run_length);
  assign end_blk = end_sum[LEN_W-1:0];

  always_comb begin
    cmd.op       = req_type;
    cmd.blk      = block;
    cmd.end_blk  = end_blk;
    cmd.last     = last;
    cmd.in_range = (CMP_W'(block) < CMP_W'(used_size));
    keep           = 1'b0;
    list_open_next = list_open;
    case (req_type)
      REQ_CONTIG: begin
        cmd.in_range   = (end_sum <= SUM_W'(used_size));
        keep           = 1'b1;
        list_open_next = 1'b0;
      end
      REQ_HEAD: begin
        keep           = 1'b1;
        list_open_next = !last;
      end
      REQ_MEMBER: begin
        // drop a member beat that belongs to no open list
        keep           = list_open;
        list_open_next = list_open && !last;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_open <= 1'b0;
    end else if (accept) begin
      list_open <= list_open_next;
    end
  end

endmodule

// ===== sv/dba_back.sv =====
// Back end: holds the allocation and pending bitmaps and executes queued commands.
// Depends on dba_pkg; reads the command queue and writes the result queue.
module dba_back #(
  parameter int BLOCK_COUNT = dba_pkg::BLOCK_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  dba_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output dba_pkg::res_t  res
);
  import dba_pkg::*;

  localparam int IDX_W = $clog2(BLOCK_COUNT);

  logic [BLOCK_COUNT-1:0] alloc, alloc_next;
  logic [BLOCK_COUNT-1:0] pending, pending_next;
  logic [STATUS_W-1:0]    lst_status, lst_status_next;
  logic [BLOCK_W-1:0]     lst_fail, lst_fail_next;
  logic                   busy, busy_next;
  logic                   c_range, c_range_next;
  logic [BLOCK_COUNT-1:0] c_mask, c_mask_next;
  logic [BLOCK_COUNT-1:0] c_hit, c_hit_next;

  logic [BLOCK_COUNT-1:0] run_mask;
  logic [BLOCK_COUNT-1:0] lowest;
  logic [IDX_W-1:0]       first_idx;
  logic [IDX_W-1:0]       idx;
  logic                   take;

  logic [BLOCK_COUNT-1:0] base_pend, pend;
  logic [STATUS_W-1:0]    base_st, st, taken_code;
  logic [BLOCK_W-1:0]     base_fb, fb;

  assign idx      = IDX_W'(cmd.blk);
  assign run_mask = ({BLOCK_COUNT{1'b1}} << cmd.blk) & ~({BLOCK_COUNT{1'b1}} << cmd.end_blk);
  assign take     = !busy && !cmd_empty && !res_full;
  assign cmd_pop  = take;

  // isolate the lowest hit of the run, then encode it
  assign lowest = c_hit & (~c_hit + BLOCK_COUNT'(1));

  always_comb begin
    first_idx = '0;
    for (int j = 0; j < BLOCK_COUNT; j++) begin
      if (lowest[j]) begin
        first_idx = first_idx | IDX_W'(j);
      end
    end
  end

  always_comb begin
    alloc_next      = alloc;
    pending_next    = pending;
    lst_status_next = lst_status;
    lst_fail_next   = lst_fail;
    busy_next       = busy;
    c_range_next    = c_range;
    c_mask_next     = c_mask;
    c_hit_next      = c_hit;
    res_push        = 1'b0;
    res             = '0;
    base_pend       = pending;
    base_st         = lst_status;
    base_fb         = lst_fail;
    taken_code      = ST_MEMBER_TAKEN;
    pend            = pending;
    st              = lst_status;
    fb              = lst_fail;

    if (busy) begin
      // contiguous claim after its run is staged: report, mark on success
      res_push  = 1'b1;
      busy_next = 1'b0;
      if (c_range) begin
        res.status = ST_RANGE;
      end else if (|c_hit) begin
        res.status     = ST_HEAD_TAKEN;
        res.fail_block = BLOCK_W'(first_idx);
      end else begin
        res.status = ST_OK;
        alloc_next = alloc | c_mask;
      end
    end else if (take) begin
      case (cmd.op)
        REQ_CONTIG: begin
          // abandon any open list, stage the run
          pending_next    = '0;
          lst_status_next = ST_OK;
          lst_fail_next   = '0;
          busy_next       = 1'b1;
          c_range_next    = !cmd.in_range;
          c_mask_next     = run_mask;
          c_hit_next      = alloc & run_mask;
        end
        REQ_HEAD, REQ_MEMBER: begin
          if (cmd.op == REQ_HEAD) begin
            base_pend  = '0;
            base_st    = ST_OK;
            base_fb    = '0;
            taken_code = ST_HEAD_TAKEN;
          end
          pend = base_pend;
          st   = base_st;
          fb   = base_fb;
          if (!cmd.in_range) begin
            if (base_st == ST_OK) begin
              st = ST_RANGE;
              fb = '0;
            end
          end else begin
            if (alloc[idx] && base_st == ST_OK) begin
              st = taken_code;
              fb = cmd.blk;
            end
            pend = base_pend | (BLOCK_COUNT'(1) << idx);
          end
          if (cmd.last) begin
            // commit all or nothing, then close the list
            res_push        = 1'b1;
            res.status      = st;
            res.fail_block  = fb;
            if (st == ST_OK) begin
              alloc_next = alloc | pend;
            end
            pending_next    = '0;
            lst_status_next = ST_OK;
            lst_fail_next   = '0;
          end else begin
            pending_next    = pend;
            lst_status_next = st;
            lst_fail_next   = fb;
          end
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    c_range <= c_range_next;
    c_mask  <= c_mask_next;
    c_hit   <= c_hit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc      <= '0;
      pending    <= '0;
      lst_status <= ST_OK;
      lst_fail   <= '0;
      busy       <= 1'b0;
    end else begin
      alloc      <= alloc_next;
      pending    <= pending_next;
      lst_status <= lst_status_next;
      lst_fail   <= lst_fail_next;
      busy       <= busy_next;
    end
  end

endmodule

// ===== tb/dba_claim_checker.sv =====
`timescale 1ns / 100ps
// Checker for the disk block allocation bitmap: watches the request, result and
// cfg channels, predicts each reply and compares it. Depends on dba_pkg.
module dba_claim_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  logic [dba_pkg::REQ_W-1:0]    req_type,
  input  logic [dba_pkg::BLOCK_W-1:0]  block,
  input  logic [dba_pkg::LEN_W-1:0]    run_length,
  input  logic                         last,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [dba_pkg::STATUS_W-1:0] status,
  input  logic [dba_pkg::BLOCK_W-1:0]  fail_block,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [dba_pkg::DISK_W-1:0]   cfg_data,
  output int                           mismatches,
  output int                           waiting
);
  import dba_pkg::*;

  localparam int NBLK = BLOCK_COUNT_DEF;

  // Shadow copy of the bitmap and the open list.
  bit [NBLK-1:0]       committed;
  bit [NBLK-1:0]       gathered;
  bit                  list_live;
  logic [STATUS_W-1:0] list_code;
  logic [BLOCK_W-1:0]  list_blk;
  logic [DISK_W-1:0]   disk_blocks;

  res_t reply_q[$];
  res_t want;
  res_t got;
  bit   produces;

  function automatic int unsigned usable_blocks();
    return (disk_blocks > NBLK) ? NBLK : 32'(disk_blocks);
  endfunction

  task automatic drop_list();
    gathered  = '0;
    list_live = 1'b0;
    list_code = ST_OK;
    list_blk  = '0;
  endtask

  // Check one list block against the committed map only, then gather it.
  task automatic gather_block(input int unsigned b, input logic [STATUS_W-1:0] code);
    if (b >= usable_blocks()) begin
      if (list_code == ST_OK) begin
        list_code = ST_RANGE;
        list_blk  = '0;
      end
    end else begin
      if (committed[b] && list_code == ST_OK) begin
        list_code = code;
        list_blk  = b[BLOCK_W-1:0];
      end
      gathered[b] = 1'b1;
    end
  endtask

  task automatic close_list(output res_t outcome);
    if (list_code == ST_OK) committed = committed | gathered;
    outcome.status     = list_code;
    outcome.fail_block = list_blk;
    drop_list();
  endtask

  task automatic predict_claim(input logic [REQ_W-1:0] req, input logic [BLOCK_W-1:0] blk,
                               input logic [LEN_W-1:0] len, input logic lst,
                               output bit has_reply, output res_t outcome);
    int unsigned stop;
    int unsigned i;
    bit hit;
    has_reply = 1'b0;
    outcome   = '0;
    case (req)
      REQ_CONTIG: begin
        stop = 32'(blk) + 32'(len);
        if (list_live) drop_list();
        has_reply          = 1'b1;
        outcome.status     = ST_OK;
        outcome.fail_block = '0;
        if (stop > usable_blocks()) begin
          outcome.status = ST_RANGE;
        end else begin
          hit = 1'b0;
          for (i = 32'(blk); i < stop; i++) begin
            if (!hit && committed[i]) begin
              hit                = 1'b1;
              outcome.status     = ST_HEAD_TAKEN;
              outcome.fail_block = i[BLOCK_W-1:0];
            end
          end
          if (!hit) for (i = 32'(blk); i < stop; i++) committed[i] = 1'b1;
        end
      end
      REQ_HEAD: begin
        drop_list();
        list_live = 1'b1;
        gather_block(32'(blk), ST_HEAD_TAKEN);
        if (lst) begin
          close_list(outcome);
          has_reply = 1'b1;
        end
      end
      REQ_MEMBER: begin
        if (list_live) begin
          gather_block(32'(blk), ST_MEMBER_TAKEN);
          if (lst) begin
            close_list(outcome);
            has_reply = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      committed   = '0;
      drop_list();
      disk_blocks = DISK_SIZE_RESET;
      reply_q.delete();
      mismatches  = 0;
      waiting    <= 0;
    end else begin
      // Compare first, so a reply never meets an expectation queued at the same edge.
      if (pop && !empty) begin
        if (reply_q.size() == 0) begin
          $display("%0t: reply with none expected, actual status %0d fail_block %0d",
                   $time, status, fail_block);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
          end
          if (fail_block !== want.fail_block) begin
            $display("%0t: fail_block expected %0d actual %0d",
                     $time, want.fail_block, fail_block);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) disk_blocks = cfg_data;
      if (push && !full) begin
        predict_claim(req_type, block, run_length, last, produces, got);
        if (produces) reply_q.push_back(got);
      end
      waiting <= reply_q.size();
    end
  end

endmodule

// ===== tb/disk_block_allocation_bitmap_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the disk block allocation bitmap: clock, reset, request and
// cfg stimulus, result pacing and the verdict. Depends on dba_pkg and dba_claim_checker.
module disk_block_allocation_bitmap_tb;
  import dba_pkg::*;

  localparam int NBLK         = BLOCK_COUNT_DEF;
  localparam int DRAIN_CYCLES = 16;    // covers both queues plus the back end
  localparam int IDLE_LIMIT   = 2000;  // far above any gap, stall or drain
  localparam int PHASE_ITEMS  = 265;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                push       = 1'b0;
  logic                full;
  logic [REQ_W-1:0]    req_type   = REQ_CONTIG;
  logic [BLOCK_W-1:0]  block      = '0;
  logic [LEN_W-1:0]    run_length = '0;
  logic                last       = 1'b0;
  logic                empty;
  logic                pop        = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [BLOCK_W-1:0]  fail_block;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [DISK_W-1:0]   cfg_data   = '0;

  int          mismatches;
  int          waiting;
  int          idle_cycles = 0;
  int unsigned span        = 32'(DISK_SIZE_RESET);  // disk size as the block uses it
  bit          calm        = 1'b0;                  // no idling on either side once set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  disk_block_allocation_bitmap dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .block      (block),
    .run_length (run_length),
    .last       (last),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .fail_block (fail_block),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  dba_claim_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .block      (block),
    .run_length (run_length),
    .last       (last),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .fail_block (fail_block),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  // Watchdog: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: hold pop low in random bursts, release it for random stretches.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Drive one request beat and hold it until accepted. A random gap may come
  // first; without one, the next beat follows back to back with push held high.
  task automatic send_item(input logic [REQ_W-1:0] req, input int unsigned blk,
                           input int unsigned len, input logic lst);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push       <= 1'b1;
    req_type   <= req;
    block      <= blk[BLOCK_W-1:0];
    run_length <= len[LEN_W-1:0];
    last       <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push, let every reply drain and the back end settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write disk_size only while the block is idle.
  task automatic set_disk_size(input int unsigned size);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= size[DISK_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    span = (size > NBLK) ? NBLK : size;
  endtask

  // Favor blocks inside the disk and around its edge, with some anywhere.
  function automatic int unsigned pick_block();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3 || span == 0) return $urandom_range(0, NBLK - 1);
    if (roll < 5) return $urandom_range((span > 3) ? span - 3 : 0, (span < NBLK) ? span : NBLK - 1);
    return $urandom_range(0, span - 1);
  endfunction

  // Run lengths: mostly short, some that end right at the disk edge or one past it.
  function automatic int unsigned pick_length(input int unsigned blk);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 3);
    if (roll < 55) return (blk <= span) ? span - blk + $urandom_range(0, 1) : 0;
    if (roll < 80) return $urandom_range(0, 16);
    if (roll < 92) return $urandom_range(0, NBLK);
    return $urandom_range(NBLK + 1, 255);
  endfunction

  // Random claims until quota beats are sent. Most are well-formed contiguous
  // or list claims; the rest are truncated lists, stray members and unused
  // request codes. Every beat counts toward the quota.
  task automatic random_claims(input int quota);
    int          sent;
    int          members;
    int          k;
    int unsigned roll;
    int unsigned blk;
    bit          cut;
    sent = 0;
    while (sent < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        blk = pick_block();
        send_item(REQ_CONTIG, blk, pick_length(blk), 1'($urandom_range(0, 1)));
        sent++;
      end else if (roll < 86) begin
        members = $urandom_range(0, 5);
        cut     = ($urandom_range(0, 9) == 0);
        send_item(REQ_HEAD, pick_block(), $urandom_range(0, 255), (members == 0) && !cut);
        for (k = 1; k <= members; k++)
          send_item(REQ_MEMBER, pick_block(), $urandom_range(0, 255), (k == members) && !cut);
        sent += members + 1;
      end else if (roll < 93) begin
        send_item(REQ_MEMBER, pick_block(), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_item(REQ_MEMBER | REQ_HEAD, $urandom_range(0, NBLK - 1), $urandom_range(0, 255),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset disk size of 100.
    send_item(REQ_CONTIG, 0, 0, 1'b0);           // zero length at the start
    send_item(REQ_CONTIG, 100, 0, 1'b1);         // zero length right at the disk edge
    send_item(REQ_CONTIG, 101, 0, 1'b0);         // zero length past the edge
    send_item(REQ_CONTIG, 0, 4, 1'b0);           // mark 0..3
    send_item(REQ_CONTIG, 2, 3, 1'b0);           // run overlaps 2..3
    send_item(REQ_CONTIG, 127, 128, 1'b1);       // block at its top, run as long as the bitmap
    send_item(REQ_CONTIG, 96, 4, 1'b0);          // run ends at the disk edge
    send_item(REQ_HEAD, 10, 255, 1'b0);          // list with a duplicate member
    send_item(REQ_MEMBER, 11, 0, 1'b0);
    send_item(REQ_MEMBER, 11, 0, 1'b0);
    send_item(REQ_MEMBER, 12, 0, 1'b1);
    send_item(REQ_HEAD, 20, 0, 1'b1);            // list of the head alone
    send_item(REQ_HEAD, 1, 0, 1'b0);             // head already taken
    send_item(REQ_MEMBER, 50, 0, 1'b1);
    send_item(REQ_HEAD, 30, 0, 1'b0);            // first error wins over later ones
    send_item(REQ_MEMBER, 2, 0, 1'b0);
    send_item(REQ_MEMBER, 3, 0, 1'b0);
    send_item(REQ_MEMBER, 120, 0, 1'b1);
    send_item(REQ_MEMBER, 60, 0, 1'b1);          // member with no list open
    send_item(REQ_MEMBER | REQ_HEAD, 127, 255, 1'b1);  // unused request code
    send_item(REQ_HEAD, 40, 0, 1'b0);            // contiguous claim abandons the list
    send_item(REQ_CONTIG, 41, 1, 1'b0);
    send_item(REQ_HEAD, 42, 0, 1'b0);            // new head abandons the list
    send_item(REQ_HEAD, 43, 0, 1'b1);
    send_item(REQ_MEMBER, 31, 0, 1'b1);          // member after the list closed

    // Random phases over several disk sizes, extremes first.
    set_disk_size(NBLK);
    random_claims(PHASE_ITEMS);
    set_disk_size(1);
    random_claims(PHASE_ITEMS);
    set_disk_size(0);
    random_claims(PHASE_ITEMS);
    set_disk_size(255);
    random_claims(PHASE_ITEMS);
    set_disk_size(NBLK + 1);
    random_claims(PHASE_ITEMS);
    set_disk_size($urandom_range(2, NBLK - 1));
    random_claims(PHASE_ITEMS);
    set_disk_size(DISK_SIZE_RESET);
    calm = 1'b1;
    random_claims(PHASE_ITEMS);

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
